[rtl/metric_table_counter_gauge_histogram_assert.svh]
// Assertion macros for the metric table checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef METRIC_TABLE_COUNTER_GAUGE_HISTOGRAM_ASSERT_SVH
`define METRIC_TABLE_COUNTER_GAUGE_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define MTCGH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("metric table check failed");

// next-cycle implication
`define MTCGH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("metric table check failed");

`endif

[rtl/mtcgh_pkg.sv]
// Shared types and constants for the metric table.
// No dependencies.
package mtcgh_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 3;
    localparam int KIND_W        = 2;

    localparam logic [64:0] KEY_TOP  = 65'd1 << KEY_BITS;
    localparam logic [63:0] KEY_MASK = 64'(KEY_TOP - 65'd1);

    localparam logic [63:0] SAT_HIGH = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_LOW  = 64'h8000_0000_0000_0000;

    localparam logic [CMD_W-1:0] CMD_ADD_COUNTER = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_GAUGE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_HIST    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INCREMENT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET         = 3'd4;
    localparam logic [CMD_W-1:0] CMD_OBSERVE     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ        = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WRONG     = 3'd5;

    localparam logic [KIND_W-1:0] KIND_COUNTER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GAUGE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HIST    = 2'd2;

    typedef struct packed {
        logic [63:0]       key;
        logic [KIND_W-1:0] kind;
        logic [63:0]       value;
        logic [31:0]       samples;
        logic [63:0]       total;
        logic [63:0]       low;
        logic [63:0]       high;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   metric_kind;
        logic [63:0]         current_value;
        logic [31:0]         sample_count;
        logic [63:0]         sample_sum;
        logic [63:0]         sample_min;
        logic [63:0]         sample_max;
        logic [CNT_W-1:0]    entries_used;
    } rsp_word_t;

endpackage

[rtl/mtcgh_if.sv]
// Request and response channel interfaces for the metric table.
// Depends on mtcgh_pkg.
interface mtcgh_req_if
    import mtcgh_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [63:0]             metric_key;
    logic signed [63:0]      operand_value;

    modport source (output valid, output command, output metric_key,
                    output operand_value, input ready);
    modport sink   (input valid, input command, input metric_key,
                    input operand_value, output ready);
endinterface

interface mtcgh_rsp_if
    import mtcgh_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [KIND_W-1:0]       metric_kind;
    logic signed [63:0]      current_value;
    logic [31:0]             sample_count;
    logic signed [63:0]      sample_sum;
    logic signed [63:0]      sample_min;
    logic signed [63:0]      sample_max;
    logic [CNT_W-1:0]        entries_used;

    modport source (output valid, output status, output metric_kind,
                    output current_value, output sample_count, output sample_sum,
                    output sample_min, output sample_max, output entries_used,
                    input ready);
    modport sink   (input valid, input status, input metric_kind,
                    input current_value, input sample_count, input sample_sum,
                    input sample_min, input sample_max, input entries_used,
                    output ready);
endinterface

[rtl/mtcgh_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mtcgh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/metric_table_counter_gauge_histogram.sv]
// Keyed metric table: counters, gauges and histograms over one entry RAM.
// Steps: accept in idle, scan the used entries for the key (stop at the first hit; an
// empty key skips the scan), execute, ALU for increment or observe (sum, min, max),
// write the entry back if it changed, register the result word; an unknown command skips to the result.
// Commands are taken only in idle, one at a time; a waiting result holds back the next one.
// Reset (async, active low) empties the table; entry RAM is not cleared. Uses mtcgh_pkg.
module metric_table_counter_gauge_histogram
    import mtcgh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mtcgh_req_if.sink     req,
    mtcgh_rsp_if.source   rsp
);

    localparam int          STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] S_SCAN  = 3'd1;
    localparam logic [STATE_W-1:0] S_EXEC  = 3'd2;
    localparam logic [STATE_W-1:0] S_ALU   = 3'd3;
    localparam logic [STATE_W-1:0] S_WRITE = 3'd4;
    localparam logic [STATE_W-1:0] S_DONE  = 3'd5;

    localparam logic [1:0] STEP_SUM = 2'd0;
    localparam logic [1:0] STEP_MIN = 2'd1;
    localparam logic [1:0] STEP_MAX = 2'd2;

    logic [STATE_W-1:0]  state_reg,   state_next;
    logic [CNT_W-1:0]    scan_reg,    scan_next;
    logic                pend_reg,    pend_next;
    logic                hit_reg,     hit_next;
    logic [CNT_W-1:0]    used_reg,    used_next;
    logic [1:0]          step_reg,    step_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [CMD_W-1:0]    cmd_reg,     cmd_next;
    logic [63:0]         key_reg,     key_next;
    logic [63:0]         val_reg,     val_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]    idx_reg,     idx_next;
    entry_t              entry_reg,   entry_next;
    logic [STATUS_W-1:0] status_reg,  status_next;
    rsp_word_t           rsp_word_reg, rsp_word_next;

    logic                ram_we;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t              rd_entry;
    logic                rd_hit;

    // shared 65-bit add/subtract unit
    logic [63:0]         alu_a;
    logic [63:0]         alu_b;
    logic                alu_sub;
    logic [64:0]         alu_sum;
    logic                alu_ovf;
    logic                alu_lt;
    logic [63:0]         alu_sat;

    mtcgh_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (entry_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign rd_hit   = pend_reg && (rd_entry.key == key_reg);

    always_comb
    begin
        alu_a   = entry_reg.value;
        alu_b   = val_reg;
        alu_sub = 1'b0;
        if (cmd_reg == CMD_OBSERVE)
        begin
            case (step_reg)
                STEP_SUM:
                begin
                    alu_a = entry_reg.total;
                end
                STEP_MIN:
                begin
                    alu_a   = val_reg;
                    alu_b   = entry_reg.low;
                    alu_sub = 1'b1;
                end
                default:
                begin
                    alu_a   = entry_reg.high;
                    alu_b   = val_reg;
                    alu_sub = 1'b1;
                end
            endcase
        end
        alu_sum = {alu_a[63], alu_a} + ({alu_b[63], alu_b} ^ {65{alu_sub}})
                  + {64'd0, alu_sub};
        alu_ovf = (alu_a[63] == alu_b[63]) && (alu_sum[63] != alu_a[63]);
        alu_sat = alu_ovf ? (alu_b[63] ? SAT_LOW : SAT_HIGH) : alu_sum[63:0];
        alu_lt  = alu_sum[64];
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        used_next      = used_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        cmp_idx_next   = cmp_idx_reg;
        idx_next       = idx_reg;
        entry_next     = entry_reg;
        status_next    = status_reg;
        rsp_word_next  = rsp_word_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = scan_reg[IDX_W-1:0];

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.command;
                    key_next    = req.metric_key & KEY_MASK;
                    val_next    = req.operand_value;
                    status_next = ST_OK;
                    hit_next    = 1'b0;
                    pend_next   = 1'b0;
                    if (req.command > CMD_READ)
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        // empty key is never found: skip the scan
                        scan_next  = ((req.metric_key & KEY_MASK) == 64'd0) ? used_reg : '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_hit)
                begin
                    entry_next = rd_entry;
                    idx_next   = cmp_idx_reg;
                    hit_next   = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_EXEC;
                end
                else if (scan_reg < used_reg)
                begin
                    ram_re       = 1'b1;
                    cmp_idx_next = scan_reg[IDX_W-1:0];
                    scan_next    = CNT_W'(scan_reg + 1'b1);
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (cmd_reg) inside
                    CMD_ADD_COUNTER, CMD_ADD_GAUGE, CMD_ADD_HIST:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_EXISTS;
                        end
                        else if (used_reg >= CNT_W'(TABLE_ENTRIES))
                        begin
                            status_next = ST_FULL;
                        end
                        else if (key_reg == 64'd0)
                        begin
                            status_next = ST_INVALID;
                        end
                        else
                        begin
                            entry_next.key     = key_reg;
                            entry_next.kind    = cmd_reg[KIND_W-1:0];
                            entry_next.value   = '0;
                            entry_next.samples = '0;
                            entry_next.total   = '0;
                            entry_next.low     = (cmd_reg == CMD_ADD_HIST) ? SAT_HIGH : '0;
                            entry_next.high    = (cmd_reg == CMD_ADD_HIST) ? SAT_LOW : '0;
                            idx_next           = used_reg[IDX_W-1:0];
                            used_next          = CNT_W'(used_reg + 1'b1);
                            hit_next           = 1'b1;
                            state_next         = S_WRITE;
                        end
                    end
                    CMD_INCREMENT:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else if (entry_reg.kind != KIND_COUNTER)
                        begin
                            status_next = ST_WRONG;
                        end
                        else
                        begin
                            step_next  = STEP_SUM;
                            state_next = S_ALU;
                        end
                    end
                    CMD_SET:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else if (entry_reg.kind != KIND_GAUGE)
                        begin
                            status_next = ST_WRONG;
                        end
                        else
                        begin
                            entry_next.value = val_reg;
                            state_next       = S_WRITE;
                        end
                    end
                    CMD_OBSERVE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else if (entry_reg.kind != KIND_HIST)
                        begin
                            status_next = ST_WRONG;
                        end
                        else
                        begin
                            entry_next.samples = entry_reg.samples + 32'd1;
                            step_next          = STEP_SUM;
                            state_next         = S_ALU;
                        end
                    end
                    CMD_READ:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        status_next = ST_INVALID;
                        hit_next    = 1'b0;
                    end
                endcase
            end

            S_ALU:
            begin
                if (cmd_reg == CMD_INCREMENT)
                begin
                    entry_next.value = alu_sat;
                    state_next       = S_WRITE;
                end
                else
                begin
                    case (step_reg)
                        STEP_SUM:
                        begin
                            entry_next.total = alu_sat;
                            step_next        = STEP_MIN;
                        end
                        STEP_MIN:
                        begin
                            if (alu_lt)
                            begin
                                entry_next.low = val_reg;
                            end
                            step_next = STEP_MAX;
                        end
                        default:
                        begin
                            if (alu_lt)
                            begin
                                entry_next.high = val_reg;
                            end
                            state_next = S_WRITE;
                        end
                    endcase
                end
            end

            S_WRITE:
            begin
                ram_we     = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_word_next.status       = status_reg;
                    rsp_word_next.entries_used = used_reg;
                    if (hit_reg)
                    begin
                        rsp_word_next.metric_kind   = entry_reg.kind;
                        rsp_word_next.current_value = entry_reg.value;
                        rsp_word_next.sample_count  = entry_reg.samples;
                        rsp_word_next.sample_sum    = entry_reg.total;
                        rsp_word_next.sample_min    = entry_reg.low;
                        rsp_word_next.sample_max    = entry_reg.high;
                    end
                    else
                    begin
                        rsp_word_next.metric_kind   = '0;
                        rsp_word_next.current_value = '0;
                        rsp_word_next.sample_count  = '0;
                        rsp_word_next.sample_sum    = '0;
                        rsp_word_next.sample_min    = '0;
                        rsp_word_next.sample_max    = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            used_reg      <= '0;
            step_reg      <= STEP_SUM;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            used_reg      <= used_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        cmp_idx_reg  <= cmp_idx_next;
        idx_reg      <= idx_next;
        entry_reg    <= entry_next;
        status_reg   <= status_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_word_reg.status;
    assign rsp.metric_kind   = rsp_word_reg.metric_kind;
    assign rsp.current_value = $signed(rsp_word_reg.current_value);
    assign rsp.sample_count  = rsp_word_reg.sample_count;
    assign rsp.sample_sum    = $signed(rsp_word_reg.sample_sum);
    assign rsp.sample_min    = $signed(rsp_word_reg.sample_min);
    assign rsp.sample_max    = $signed(rsp_word_reg.sample_max);
    assign rsp.entries_used  = rsp_word_reg.entries_used;

endmodule

[rtl/mtcgh_checker.sv]
// Port-level checks for the metric table, bound to the top level.
// Depends on mtcgh_pkg and the assertion macro header.
`include "metric_table_counter_gauge_histogram_assert.svh"

module mtcgh_checker
    import mtcgh_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [KIND_W-1:0]   rsp_metric_kind,
    input logic [31:0]         rsp_sample_count,
    input logic [CNT_W-1:0]    rsp_entries_used
);

    // a stalled result word holds
    `MTCGH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_entries_used))

    // one word in flight: ready drops after an accept
    `MTCGH_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

    // full table reported only with every entry in use
    `MTCGH_ASSERT_IMP(a_full_count, rsp_valid && rsp_ready && rsp_status == ST_FULL, rsp_entries_used == CNT_W'(TABLE_ENTRIES))

    // missing entry carries zero fields
    `MTCGH_ASSERT_IMP(a_missing_zero, rsp_valid && rsp_ready && rsp_status == ST_NOT_FOUND, rsp_metric_kind == KIND_COUNTER && rsp_sample_count == 32'd0)

endmodule

bind metric_table_counter_gauge_histogram mtcgh_checker u_mtcgh_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_metric_kind  (rsp.metric_kind),
    .rsp_sample_count (rsp.sample_count),
    .rsp_entries_used (rsp.entries_used)
);
